FILE: rtl/mi_pkg.sv
// Shared types for the modular inverse core.
// Controller state enum and the command/status structs that join
// the controller and the datapath. No dependencies.
package mi_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ALIGN,
		ST_SUB,
		ST_LIFT
	} state_t;

	typedef struct packed {
		logic load;    // take a new word from the input
		logic start;   // set up the division for one Euclid step
		logic grow;    // shift divisor and coefficient multiple up
		logic sub;     // one quotient bit: conditional subtract, shift down
		logic commit;  // last quotient bit: retire the Euclid step
		logic finish;  // lift coefficient into the output register
	} cmd_t;

	typedef struct packed {
		logic lo_zero;   // remainder is zero, iteration done
		logic can_grow;  // doubled divisor still fits under partial remainder
		logic k_zero;    // at the lowest quotient bit
	} status_t;

endpackage

FILE: rtl/mi_ctrl.sv
// Controller for the modular inverse core.
// Sequences Euclid steps and the shift/subtract division inside each.
// Uses mi_pkg (state_t, cmd_t, status_t).
module mi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  mi_pkg::status_t  status,
	output mi_pkg::cmd_t     cmd
);

	mi_pkg::state_t state_q, state_next;
	logic           out_valid_q;
	logic           out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mi_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			mi_pkg::ST_IDLE: begin
				if (in_valid)
					state_next = mi_pkg::ST_CHECK;
			end
			mi_pkg::ST_CHECK: begin
				if (status.lo_zero)
					state_next = mi_pkg::ST_LIFT;
				else
					state_next = mi_pkg::ST_ALIGN;
			end
			mi_pkg::ST_ALIGN: begin
				if (!status.can_grow)
					state_next = mi_pkg::ST_SUB;
			end
			mi_pkg::ST_SUB: begin
				if (status.k_zero)
					state_next = mi_pkg::ST_CHECK;
			end
			mi_pkg::ST_LIFT: begin
				if (out_free)
					state_next = mi_pkg::ST_IDLE;
			end
			default: state_next = mi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			mi_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			mi_pkg::ST_CHECK: begin
				cmd.start = !status.lo_zero;
			end
			mi_pkg::ST_ALIGN: begin
				cmd.grow = status.can_grow;
			end
			mi_pkg::ST_SUB: begin
				cmd.sub    = !status.k_zero;
				cmd.commit = status.k_zero;
			end
			mi_pkg::ST_LIFT: begin
				cmd.finish = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/mi_datapath.sv
// Datapath for the modular inverse core: remainder pair, coefficient pair,
// a one-bit-per-cycle shift/subtract divider that also forms prev - q*cur.
// Uses mi_pkg (cmd_t, status_t).
module mi_datapath #(
	parameter int DATA_WIDTH = 31
) (
	input  logic                  clk,
	input  mi_pkg::cmd_t          cmd,
	output mi_pkg::status_t       status,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] modulus,
	output logic [DATA_WIDTH-1:0] inverse
);

	localparam int W  = DATA_WIDTH;
	localparam int CW = DATA_WIDTH + 3;  // |coef| < 3 * 2^W mid-step
	localparam int KW = $clog2(DATA_WIDTH + 1);

	logic [W-1:0]         hi_q, lo_q, mod_q, r_q, inverse_q;
	logic [W:0]           d_q;
	logic signed [CW-1:0] prev_q, cur_q, c_q, mult_q;
	logic [KW-1:0]        k_q;

	logic                 fits;
	logic [W-1:0]         r_sub;
	logic signed [CW-1:0] c_sub;
	logic signed [CW-1:0] lifted;

	// quotient bit for the current alignment
	assign fits  = ({1'b0, r_q} >= d_q);
	assign r_sub = fits ? (r_q - d_q[W-1:0]) : r_q;
	assign c_sub = fits ? (c_q - mult_q) : c_q;

	assign lifted = prev_q[CW-1] ? (prev_q + $signed({3'b000, mod_q})) : prev_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hi_q   <= modulus;
			lo_q   <= value;
			mod_q  <= modulus;
			prev_q <= '0;
			cur_q  <= CW'(1);
		end
		if (cmd.start) begin
			r_q    <= hi_q;
			d_q    <= {1'b0, lo_q};
			c_q    <= prev_q;
			mult_q <= cur_q;
			k_q    <= '0;
		end
		if (cmd.grow) begin
			d_q    <= {d_q[W-1:0], 1'b0};
			mult_q <= mult_q <<< 1;
			k_q    <= k_q + 1'b1;
		end
		if (cmd.sub) begin
			r_q    <= r_sub;
			c_q    <= c_sub;
			d_q    <= d_q >> 1;
			mult_q <= mult_q >>> 1;
			k_q    <= k_q - 1'b1;
		end
		if (cmd.commit) begin
			hi_q   <= lo_q;
			lo_q   <= r_sub;
			prev_q <= cur_q;
			cur_q  <= c_sub;
		end
		if (cmd.finish)
			inverse_q <= lifted[W-1:0];
	end

	assign status.lo_zero  = (lo_q == '0);
	assign status.can_grow = ({d_q, 1'b0} <= {2'b00, r_q});
	assign status.k_zero   = (k_q == '0);

	assign inverse = inverse_q;

endmodule

FILE: rtl/modular_inverse_core.sv
// Modular inverse core (extended Euclid), controller plus datapath.
// Each Euclid step runs a check, the divisor alignment and the shift/subtract division;
// after the last step the coefficient is lifted into the output register and the core
// returns to idle for the next word once the output is free. A zero value goes from
// the check straight to the lift.
// Reset (arst_n, async low) clears the controller and output valid only.
module modular_inverse_core #(
	parameter int DATA_WIDTH = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] modulus,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] inverse
);

	mi_pkg::cmd_t    cmd;
	mi_pkg::status_t status;

	mi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mi_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk     (clk),
		.cmd     (cmd),
		.status  (status),
		.value   (value),
		.modulus (modulus),
		.inverse (inverse)
	);

endmodule

FILE: rtl/mi_checker.sv
// Port-level checks for modular_inverse_core, bound to the top level.
// Depends only on the top level's ports.
module mi_checker #(
	parameter int DATA_WIDTH = 31
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [DATA_WIDTH-1:0] inverse
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(inverse))
		else $error("result changed while stalled");

	// one word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again while busy");

	// a new result only appears from a word in progress
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work in progress");

endmodule

bind modular_inverse_core mi_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_mi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.inverse   (inverse)
);
